### hdl/ipdd_pkg.sv
// ----------------------------------------------------------------------------
// ipdd_pkg: shared types and constants of the IPD frame deframer
// Character codes, header and length sizes, parser state encodings and the
// item and result records passed between the deframer stages.
// ----------------------------------------------------------------------------
package ipdd_pkg;

  // sizes
  localparam int unsigned LEN_BITS   = 16;
  localparam int unsigned HC_W       = 5;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned PREFIX_LEN = 5;

  localparam logic [HC_W-1:0]     HEADER_MAX = HC_W'(23);
  localparam logic [LEN_BITS-1:0] LEN_MAX    = {LEN_BITS{1'b1}};
  localparam logic [POS_W-1:0]    PREFIX_END = POS_W'(PREFIX_LEN);
  localparam logic [POS_W-1:0]    POS_LAST   = POS_W'(PREFIX_LEN - 1);

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_P  = 8'h50;

  // frame phase, one-hot
  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HEAD = 3'b010,
    PH_PAY  = 3'b100
  } phase_e;

  // length field parse state, one-hot
  typedef enum logic [5:0] {
    FL_SKIP       = 6'b000001,
    FL_DIGITS     = 6'b000010,
    FL_DONE       = 6'b000100,
    FL_NEG        = 6'b001000,
    FL_FROZEN     = 6'b010000,
    FL_FROZEN_NEG = 6'b100000
  } flags_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_LENGTH  = 2'd1,
    ERR_TIMEOUT = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
  } item_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    err_e       error_code;
  } result_t;

  // expected character at a given prefix position
  function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      POS_W'(0): ch = CH_PLUS;
      POS_W'(1): ch = CH_UP_I;
      POS_W'(2): ch = CH_UP_P;
      POS_W'(3): ch = CH_UP_D;
      default:   ch = CH_COMMA;
    endcase
    return ch;
  endfunction

  // white space as the C library sees it
  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

endpackage

### hdl/ipdd_in_stage.sv
// ----------------------------------------------------------------------------
// ipdd_in_stage: input register of the deframer
// Captures one received byte request and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module ipdd_in_stage import ipdd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  vld_q;
  item_t item_q;

  // free when empty or drained this cycle
  assign ready_o = !vld_q || take_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

### hdl/ipdd_core.sv
// ----------------------------------------------------------------------------
// ipdd_core: frame parser state and per-byte step logic
// Prefix hunt, header length parsing and payload counting, one byte per step.
// ----------------------------------------------------------------------------
module ipdd_core import ipdd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output logic    res_vld_o,
  output result_t res_o
);

  phase_e              phase_q, phase_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [HC_W-1:0]     hc_q, hc_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  flags_e              flags_q, flags_d;
  logic [LEN_BITS-1:0] rem_q, rem_d;

  logic [7:0]          ch;
  logic                is_digit;
  logic [LEN_BITS+3:0] acc_ext;
  logic [LEN_BITS+3:0] mul_sum;
  logic [LEN_BITS-1:0] acc_sat;
  logic [HC_W-1:0]     hc_inc;
  logic [LEN_BITS-1:0] rem_dec;
  logic [POS_W-1:0]    pos_norm;
  logic                do_hunt;
  logic                hdr_end;

  assign ch       = item_i.rx_byte;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  // decimal accumulate with saturation: acc * 10 + digit
  assign acc_ext = {4'b0000, acc_q};
  assign mul_sum = (acc_ext << 3) + (acc_ext << 1) + {{LEN_BITS{1'b0}}, ch[3:0]};
  assign acc_sat = (mul_sum > {4'b0000, LEN_MAX}) ? LEN_MAX : mul_sum[LEN_BITS-1:0];

  assign hc_inc   = hc_q + 1'b1;
  assign rem_dec  = rem_q - 1'b1;
  assign pos_norm = (pos_q > POS_LAST) ? '0 : pos_q;

  // next state and result for the byte at the input register
  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    hc_d      = hc_q;
    acc_d     = acc_q;
    flags_d   = flags_q;
    rem_d     = rem_q;
    res_vld_o = 1'b0;
    res_o     = '{payload_valid: 1'b0, payload_byte: 8'h00, last_of_frame: 1'b0,
                  error_code: ERR_NONE};
    do_hunt   = 1'b0;
    hdr_end   = 1'b0;

    case (phase_q)
      PH_PAY: begin
        if (rem_q == '0) begin
          do_hunt = 1'b1;
        end else if (item_i.timed_out) begin
          res_vld_o        = 1'b1;
          res_o.error_code = ERR_TIMEOUT;
        end else begin
          rem_d               = rem_dec;
          res_vld_o           = 1'b1;
          res_o.payload_valid = 1'b1;
          res_o.payload_byte  = ch;
          if (rem_dec == '0) begin
            phase_d             = PH_HUNT;
            pos_d               = '0;
            res_o.last_of_frame = 1'b1;
          end
        end
      end

      PH_HEAD: begin
        if (item_i.timed_out) begin
          phase_d          = PH_HUNT;
          pos_d            = '0;
          res_vld_o        = 1'b1;
          res_o.error_code = ERR_TIMEOUT;
        end else begin
          if (ch == CH_COLON) begin
            hdr_end = 1'b1;
          end else begin
            // length field parse
            if ((flags_q == FL_FROZEN) || (flags_q == FL_FROZEN_NEG)) begin
              flags_d = flags_q;
            end else if (ch == CH_NUL) begin
              flags_d = (flags_q == FL_NEG) ? FL_FROZEN_NEG : FL_FROZEN;
            end else if (ch == CH_COMMA) begin
              acc_d   = '0;
              flags_d = FL_SKIP;
            end else begin
              case (flags_q)
                FL_SKIP: begin
                  if (is_space(ch)) begin
                    flags_d = FL_SKIP;
                  end else if (ch == CH_MINUS) begin
                    flags_d = FL_NEG;
                  end else if (ch == CH_PLUS) begin
                    flags_d = FL_DIGITS;
                  end else if (is_digit) begin
                    acc_d   = acc_sat;
                    flags_d = FL_DIGITS;
                  end else begin
                    flags_d = FL_DONE;
                  end
                end
                FL_DIGITS: begin
                  if (is_digit) begin
                    acc_d = acc_sat;
                  end else begin
                    flags_d = FL_DONE;
                  end
                end
                default: flags_d = flags_q;
              endcase
            end
            hc_d    = hc_inc;
            hdr_end = (hc_inc >= HEADER_MAX);
          end

          // header done: check length, then open the payload
          if (hdr_end) begin
            if ((flags_d == FL_NEG) || (flags_d == FL_FROZEN_NEG) || (acc_d == '0)) begin
              phase_d          = PH_HUNT;
              pos_d            = '0;
              res_vld_o        = 1'b1;
              res_o.error_code = ERR_LENGTH;
            end else begin
              rem_d   = acc_d;
              phase_d = PH_PAY;
            end
          end
        end
      end

      default: do_hunt = 1'b1;
    endcase

    // prefix hunt, restarting on a plus sign
    if (do_hunt) begin
      phase_d = PH_HUNT;
      if (item_i.timed_out) begin
        pos_d            = '0;
        res_vld_o        = 1'b1;
        res_o.error_code = ERR_TIMEOUT;
      end else if (ch == prefix_char(pos_norm)) begin
        if ((pos_norm + 1'b1) == PREFIX_END) begin
          pos_d   = '0;
          phase_d = PH_HEAD;
          hc_d    = '0;
          acc_d   = '0;
          flags_d = FL_SKIP;
        end else begin
          pos_d = pos_norm + 1'b1;
        end
      end else begin
        pos_d = (ch == CH_PLUS) ? POS_W'(1) : '0;
      end
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      hc_q    <= '0;
      acc_q   <= '0;
      flags_q <= FL_SKIP;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      hc_q    <= hc_d;
      acc_q   <= acc_d;
      flags_q <= flags_d;
      rem_q   <= rem_d;
    end
  end

  // checks
  a_pay_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (rem_q != '0))
    else $error("payload phase with zero count");

  a_last_in_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.last_of_frame) |-> (res_o.payload_valid && (phase_q == PH_PAY)))
    else $error("frame end outside payload");

  a_last_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_vld_o && res_o.last_of_frame) |=> (phase_q == PH_HUNT))
    else $error("no return to hunt after frame end");

  a_timeout_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.timed_out |-> (res_vld_o && (res_o.error_code == ERR_TIMEOUT)))
    else $error("timeout not reported");

  a_payload_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_o && res_o.payload_valid) |-> (res_o.error_code == ERR_NONE))
    else $error("payload byte carries an error");

endmodule

### hdl/ipdd_out_stage.sv
// ----------------------------------------------------------------------------
// ipdd_out_stage: result register of the deframer
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module ipdd_out_stage import ipdd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    vld_q;
  result_t res_q;

  // room when empty or draining this cycle
  assign free_o = !vld_q || ready_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (free_o) begin
      vld_q <= load_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

### hdl/ipd_frame_deframer.sv
// ----------------------------------------------------------------------------
// ipd_frame_deframer: IPD frame deframer top level
// Hunts for the +IPD, prefix in received bytes, parses the header length and
// passes the counted payload bytes through, reporting length and timeout
// errors.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata            | tuser                              | tlast
//  s_axis   | in  | [7:0] rx_byte    | [0] timed_out                      | -
//  m_axis   | out | [7:0] payload_b. | [0] payload_valid, [2:1] error_code| last_of_frame
//
//  one byte per cycle sustained while the result side takes results; input and
//  result are registered, with the single parser step between the two registers
//  bytes that give no result (hunt, header) never wait for the result side
//  a stalled result blocks the parser only when the next byte has a result
//  asynchronous active-low reset returns to prefix hunt with empty registers
// ----------------------------------------------------------------------------
module ipd_frame_deframer import ipdd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] timed_out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic [2:0] m_axis_tuser,   // [0] payload_valid, [2:1] error_code
  output logic       m_axis_tlast    // last_of_frame
);

  item_t   in_item;
  item_t   cur_item;
  logic    cur_vld;
  logic    step;
  logic    res_vld;
  result_t res;
  logic    out_free;
  result_t out_res;

  assign in_item = '{rx_byte: s_axis_tdata, timed_out: s_axis_tuser};

  // a byte steps when its result, if any, has room
  assign step = cur_vld && (!res_vld || out_free);

  ipdd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_vld),
    .take_i  (step),
    .item_o  (cur_item)
  );

  ipdd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (cur_item),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  ipdd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_vld),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // result fields onto the stream
  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tuser = {out_res.error_code, out_res.payload_valid};
  assign m_axis_tlast = out_res.last_of_frame;

endmodule
